>>> design/pvp_pkg.sv
`timescale 1ns / 1ps

package pvp_pkg;

    // default datapath shape
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed register widths
    localparam int TRIG_WIDTH  = 18;
    localparam int FOCAL_WIDTH = 24;

    // register file addressing
    localparam int CFG_AW = 3;

    localparam logic [CFG_AW-1:0] REG_CAMERA_X       = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CAMERA_Y       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CAMERA_Z       = 3'd2;
    localparam logic [CFG_AW-1:0] REG_YAW_COSINE     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_YAW_SINE       = 3'd4;
    localparam logic [CFG_AW-1:0] REG_FOCAL_DISTANCE = 3'd5;

    // reset values, raw signed codes with 16 fraction bits (Q2.16 trig, Q8.16 focal)
    localparam logic signed [TRIG_WIDTH-1:0]  YAW_COSINE_RST     = 18'sd52;
    localparam logic signed [TRIG_WIDTH-1:0]  YAW_SINE_RST       = 18'sd65536;
    localparam logic signed [FOCAL_WIDTH-1:0] FOCAL_DISTANCE_RST = -24'sd131072;

endpackage

>>> design/perspective_vertex_project.sv
`timescale 1ns / 1ps

// Perspective vertex projection. Each item is one world vertex; the camera
// offset is rotated by the yaw cosine/sine, tested for depth >= 0 and divided
// through by (depth - focal) to give saturated screen x/y. Throughput is one
// vertex per clock while the output is not stalled. The pipeline has five
// stages of subtract, rotate multiply, shift, magnitude and numerator
// multiply, then a restoring divider with one quotient bit per stage for
// QW = max(COORD_WIDTH + 20 - FRAC_BITS, COORD_WIDTH + 1) quotient bits, then
// the output register. A one-entry input skid takes an item while the output
// is stalled. Registers are written through cfg_we/cfg_addr/cfg_wdata and
// must only change while no items are in flight.
module perspective_vertex_project #(
    parameter int COORD_WIDTH = pvp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = pvp_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [pvp_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [((COORD_WIDTH > pvp_pkg::FOCAL_WIDTH) ? COORD_WIDTH
                   : pvp_pkg::FOCAL_WIDTH)-1:0] cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_y,
    input  logic signed [COORD_WIDTH-1:0] s_vertex_z,
    input  logic                          s_polygon_end,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_visible,
    output logic signed [COORD_WIDTH-1:0] m_screen_x,
    output logic signed [COORD_WIDTH-1:0] m_screen_y,
    output logic                          m_saturated,
    output logic                          m_polygon_last
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int TW  = pvp_pkg::TRIG_WIDTH;
    localparam int FW  = pvp_pkg::FOCAL_WIDTH;
    localparam int D   = CW + 1;               // camera offset
    localparam int P   = D + TW;               // rotate products
    localparam int S   = P + 1;                // rotate sums
    localparam int L   = S - FB;               // lateral / depth
    localparam int NN  = (L > D) ? L : D;      // dividend magnitude
    localparam int QW  = NN;                   // quotient magnitude
    localparam int NW  = NN + FW;              // |f| * |n|
    localparam int DW  = ((L > FW) ? L : FW) + 1;  // |f| + depth

    localparam logic [QW-1:0] POS_LIMIT = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic [QW-1:0] NEG_LIMIT = {{(QW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic                valid;
        logic                pol;
        logic signed [D-1:0] dx;
        logic signed [D-1:0] dy;
        logic signed [D-1:0] dz;
    } st1_t;

    typedef struct packed {
        logic                valid;
        logic                pol;
        logic signed [D-1:0] dz;
        logic signed [P-1:0] pyc;
        logic signed [P-1:0] pxs;
        logic signed [P-1:0] pxc;
        logic signed [P-1:0] pys;
    } st2_t;

    typedef struct packed {
        logic                valid;
        logic                pol;
        logic signed [D-1:0] dz;
        logic signed [L-1:0] lat;
        logic signed [L-1:0] dep;
    } st3_t;

    typedef struct packed {
        logic           valid;
        logic           pol;
        logic           vis;
        logic           neg_x;
        logic           neg_y;
        logic [NN-1:0]  mag_x;
        logic [NN-1:0]  mag_y;
        logic [DW-1:0]  den;
    } st4_t;

    typedef struct packed {
        logic           valid;
        logic           pol;
        logic           vis;
        logic           neg_x;
        logic           neg_y;
        logic [DW-1:0]  den;
        logic [DW-1:0]  rx;
        logic [DW-1:0]  ry;
        logic [QW-1:0]  nx;
        logic [QW-1:0]  ny;
        logic [QW-1:0]  qx;
        logic [QW-1:0]  qy;
    } div_t;

    // one restoring step: bring down the next dividend bit, try the subtract
    function automatic div_t div_step(div_t d);
        logic [DW:0] tx;
        logic [DW:0] ty;
        div_t        o;
        o  = d;
        tx = {d.rx, d.nx[QW-1]};
        ty = {d.ry, d.ny[QW-1]};
        if (tx >= {1'b0, d.den}) begin
            o.rx = DW'(tx - {1'b0, d.den});
            o.qx = {d.qx[QW-2:0], 1'b1};
        end else begin
            o.rx = tx[DW-1:0];
            o.qx = {d.qx[QW-2:0], 1'b0};
        end
        if (ty >= {1'b0, d.den}) begin
            o.ry = DW'(ty - {1'b0, d.den});
            o.qy = {d.qy[QW-2:0], 1'b1};
        end else begin
            o.ry = ty[DW-1:0];
            o.qy = {d.qy[QW-2:0], 1'b0};
        end
        o.nx = {d.nx[QW-2:0], 1'b0};
        o.ny = {d.ny[QW-2:0], 1'b0};
        return o;
    endfunction

    // configuration registers
    logic signed [CW-1:0] camera_x_reg;
    logic signed [CW-1:0] camera_y_reg;
    logic signed [CW-1:0] camera_z_reg;
    logic signed [TW-1:0] yaw_cosine_reg;
    logic signed [TW-1:0] yaw_sine_reg;
    logic signed [FW-1:0] focal_distance_reg;
    logic [FW-1:0]        fmag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_x_reg       <= '0;
            camera_y_reg       <= '0;
            camera_z_reg       <= '0;
            yaw_cosine_reg     <= pvp_pkg::YAW_COSINE_RST;
            yaw_sine_reg       <= pvp_pkg::YAW_SINE_RST;
            focal_distance_reg <= pvp_pkg::FOCAL_DISTANCE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                pvp_pkg::REG_CAMERA_X:       camera_x_reg       <= cfg_wdata[CW-1:0];
                pvp_pkg::REG_CAMERA_Y:       camera_y_reg       <= cfg_wdata[CW-1:0];
                pvp_pkg::REG_CAMERA_Z:       camera_z_reg       <= cfg_wdata[CW-1:0];
                pvp_pkg::REG_YAW_COSINE:     yaw_cosine_reg     <= cfg_wdata[TW-1:0];
                pvp_pkg::REG_YAW_SINE:       yaw_sine_reg       <= cfg_wdata[TW-1:0];
                pvp_pkg::REG_FOCAL_DISTANCE: focal_distance_reg <= cfg_wdata[FW-1:0];
                default: ;
            endcase
        end
    end

    // focal of zero or more acts as -1 LSB
    assign fmag = focal_distance_reg[FW-1] ? (~focal_distance_reg + 1'b1) : FW'(1);

    logic          m_valid_reg;
    logic          m_visible_reg;
    logic [CW-1:0] m_screen_x_reg;
    logic [CW-1:0] m_screen_y_reg;
    logic          m_saturated_reg;
    logic          m_polygon_last_reg;

    // pipeline advances unless the output holds an untaken item
    logic pipe_en;
    assign pipe_en = !m_valid_reg || m_ready;

    // input skid
    logic                 skid_valid_reg;
    logic signed [CW-1:0] skid_x_reg;
    logic signed [CW-1:0] skid_y_reg;
    logic signed [CW-1:0] skid_z_reg;
    logic                 skid_pol_reg;

    assign s_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
            skid_x_reg     <= s_vertex_x;
            skid_y_reg     <= s_vertex_y;
            skid_z_reg     <= s_vertex_z;
            skid_pol_reg   <= s_polygon_end;
        end
    end

    st1_t st1_next, st1_reg;
    st2_t st2_next, st2_reg;
    st3_t st3_next, st3_reg;
    st4_t st4_next, st4_reg;
    div_t div_next [0:QW];
    div_t div_reg  [0:QW];

    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    logic signed [S-1:0]  sum_lat;
    logic signed [S-1:0]  sum_dep;
    logic signed [NN-1:0] ext_lat;
    logic signed [NN-1:0] ext_dz;
    logic [NW-1:0]        num_x;
    logic [NW-1:0]        num_y;

    always_comb begin
        in_x = skid_valid_reg ? skid_x_reg : s_vertex_x;
        in_y = skid_valid_reg ? skid_y_reg : s_vertex_y;
        in_z = skid_valid_reg ? skid_z_reg : s_vertex_z;

        st1_next.valid = skid_valid_reg || s_valid;
        st1_next.pol   = skid_valid_reg ? skid_pol_reg : s_polygon_end;
        st1_next.dx    = D'(in_x) - D'(camera_x_reg);
        st1_next.dy    = D'(in_y) - D'(camera_y_reg);
        st1_next.dz    = D'(in_z) - D'(camera_z_reg);

        st2_next.valid = st1_reg.valid;
        st2_next.pol   = st1_reg.pol;
        st2_next.dz    = st1_reg.dz;
        st2_next.pyc   = P'(st1_reg.dy) * P'(yaw_cosine_reg);
        st2_next.pxs   = P'(st1_reg.dx) * P'(yaw_sine_reg);
        st2_next.pxc   = P'(st1_reg.dx) * P'(yaw_cosine_reg);
        st2_next.pys   = P'(st1_reg.dy) * P'(yaw_sine_reg);

        // arithmetic shift right = floor
        sum_lat        = S'(st2_reg.pyc) - S'(st2_reg.pxs);
        sum_dep        = S'(st2_reg.pxc) + S'(st2_reg.pys);
        st3_next.valid = st2_reg.valid;
        st3_next.pol   = st2_reg.pol;
        st3_next.dz    = st2_reg.dz;
        st3_next.lat   = sum_lat[S-1:FB];
        st3_next.dep   = sum_dep[S-1:FB];

        // work in magnitudes; quotient sign follows the dividend
        ext_lat        = NN'(st3_reg.lat);
        ext_dz         = NN'(st3_reg.dz);
        st4_next.valid = st3_reg.valid;
        st4_next.pol   = st3_reg.pol;
        st4_next.vis   = !st3_reg.dep[L-1];
        st4_next.neg_x = st3_reg.lat[L-1];
        st4_next.neg_y = st3_reg.dz[D-1];
        st4_next.mag_x = st3_reg.lat[L-1] ? -ext_lat : ext_lat;
        st4_next.mag_y = st3_reg.dz[D-1] ? -ext_dz : ext_dz;
        st4_next.den   = DW'(fmag) + DW'(st3_reg.dep);

        // for visible vertices (depth >= 0) the top bits of the dividend are below the divisor
        num_x             = NW'(fmag) * NW'(st4_reg.mag_x);
        num_y             = NW'(fmag) * NW'(st4_reg.mag_y);
        div_next[0].valid = st4_reg.valid;
        div_next[0].pol   = st4_reg.pol;
        div_next[0].vis   = st4_reg.vis;
        div_next[0].neg_x = st4_reg.neg_x;
        div_next[0].neg_y = st4_reg.neg_y;
        div_next[0].den   = st4_reg.den;
        div_next[0].rx    = DW'(num_x[NW-1:QW]);
        div_next[0].ry    = DW'(num_y[NW-1:QW]);
        div_next[0].nx    = num_x[QW-1:0];
        div_next[0].ny    = num_y[QW-1:0];
        div_next[0].qx    = '0;
        div_next[0].qy    = '0;

        for (int k = 0; k < QW; k++) begin
            div_next[k+1] = div_step(div_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg.valid <= 1'b0;
            st2_reg.valid <= 1'b0;
            st3_reg.valid <= 1'b0;
            st4_reg.valid <= 1'b0;
            for (int k = 0; k <= QW; k++) begin
                div_reg[k].valid <= 1'b0;
            end
        end else if (pipe_en) begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            div_reg <= div_next;
        end
    end

    // sign, clamp and output register
    div_t          fin;
    logic [QW-1:0] neg_qx;
    logic [QW-1:0] neg_qy;
    logic          sat_x;
    logic          sat_y;
    logic [CW-1:0] sx_next;
    logic [CW-1:0] sy_next;
    logic          sat_next;

    always_comb begin
        fin    = div_reg[QW];
        neg_qx = -fin.qx;
        neg_qy = -fin.qy;
        sat_x  = fin.neg_x ? (fin.qx > NEG_LIMIT) : (fin.qx > POS_LIMIT);
        sat_y  = fin.neg_y ? (fin.qy > NEG_LIMIT) : (fin.qy > POS_LIMIT);
        if (!fin.vis) begin
            sx_next  = '0;
            sy_next  = '0;
            sat_next = 1'b0;
        end else begin
            if (sat_x) begin
                sx_next = fin.neg_x ? COORD_MIN : COORD_MAX;
            end else begin
                sx_next = fin.neg_x ? neg_qx[CW-1:0] : fin.qx[CW-1:0];
            end
            if (sat_y) begin
                sy_next = fin.neg_y ? COORD_MIN : COORD_MAX;
            end else begin
                sy_next = fin.neg_y ? neg_qy[CW-1:0] : fin.qy[CW-1:0];
            end
            sat_next = sat_x || sat_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg        <= fin.valid;
            m_visible_reg      <= fin.vis;
            m_screen_x_reg     <= sx_next;
            m_screen_y_reg     <= sy_next;
            m_saturated_reg    <= sat_next;
            m_polygon_last_reg <= fin.pol;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_visible      = m_visible_reg;
    assign m_screen_x     = m_screen_x_reg;
    assign m_screen_y     = m_screen_y_reg;
    assign m_saturated    = m_saturated_reg;
    assign m_polygon_last = m_polygon_last_reg;

`ifndef SYNTHESIS
    a_hidden_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> m_screen_x == '0 && m_screen_y == '0 && !m_saturated)
        else $error("hidden vertex with nonzero screen result");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_screen_x == COORD_MAX || m_screen_x == COORD_MIN ||
            m_screen_y == COORD_MAX || m_screen_y == COORD_MIN)
        else $error("saturated flag without a clamped coordinate");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !pipe_en |=> skid_valid_reg && $stable(skid_x_reg))
        else $error("skid item dropped while pipeline stalled");
`endif

endmodule
